// ===== design/bccc_pkg.sv =====
`timescale 1ns / 1ps
// Braille cell command controller: shared package.
// Command bytes, result kinds, register indexes, sequencer states and helpers.
package bccc_pkg;

  localparam int unsigned PeriodW = 19;
  localparam int unsigned LevelW  = 10;
  localparam int unsigned VibW    = 13;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [PeriodW-1:0] BlinkPeriodRst = 19'd500000;
  localparam logic [LevelW-1:0]  NoneAboveRst   = 10'd716;
  localparam logic [LevelW-1:0]  SmallBelowRst  = 10'd206;
  localparam logic [LevelW-1:0]  LargeAboveRst  = 10'd306;
  localparam logic [LevelW-1:0]  LargeBelowRst  = 10'd615;
  localparam logic [VibW-1:0]    AckVibRst      = 13'd100;
  localparam logic [VibW-1:0]    LongVibRst     = 13'd5000;
  localparam logic [VibW-1:0]    VibLimit       = 13'd5000;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_BLINK_PERIOD = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_NONE_ABOVE   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SMALL_BELOW  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_LARGE_ABOVE  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LARGE_BELOW  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ACK_VIB      = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_LONG_VIB     = 3'd6;

  // host command and reply bytes
  localparam logic [7:0] CMD_IGNORE   = 8'hFF;
  localparam logic [7:0] CMD_LOAD     = 8'h40;
  localparam logic [7:0] CMD_READ     = 8'h2B;
  localparam logic [7:0] CMD_TEST     = 8'h5F;
  localparam logic [7:0] CMD_QUERY    = 8'h51;
  localparam logic [7:0] CMD_MEASURE  = 8'h45;
  localparam logic [7:0] CMD_HIGH     = 8'h48;
  localparam logic [7:0] CMD_LOW      = 8'h4C;
  localparam logic [7:0] CMD_UNBLINK  = 8'hC0;
  localparam logic [7:0] CMD_LONG_VIB = 8'h21;
  localparam logic [3:0] CMD_BLINK_HI = 4'hB;
  localparam logic [3:0] BLINK_MAX_K  = 4'd9;
  localparam logic [7:0] CHR_ACK      = 8'h41;
  localparam logic [7:0] RPL_OK       = 8'h4B;
  localparam logic [7:0] RPL_ERR      = 8'h45;
  localparam logic [7:0] RPL_NAK      = 8'h4E;
  localparam logic [7:0] PAT_EDGE     = 8'h3F;
  localparam logic [7:0] PAT_INNER    = 8'h30;

  typedef enum logic [1:0] {
    KIND_REPLY = 2'd0,
    KIND_CELL  = 2'd1,
    KIND_VIB   = 2'd2,
    KIND_ALL   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    EXP_UNKNOWN = 3'd0,
    EXP_NONE    = 3'd1,
    EXP_SMALL   = 3'd2,
    EXP_LARGE   = 3'd3,
    EXP_OTHER   = 3'd4
  } exp_e;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_EXEC  = 9'b000000010,
    S_BLINK = 9'b000000100,
    S_FILL  = 9'b000001000,
    S_RD    = 9'b000010000,
    S_CELL  = 9'b000100000,
    S_VIB   = 9'b001000000,
    S_ALL   = 9'b010000000,
    S_REPLY = 9'b100000000
  } state_e;

  function automatic logic [7:0] class_char(exp_e code);
    logic [7:0] c;
    c = 8'h2D;
    case (code)
      EXP_NONE:  c = 8'h30;
      EXP_SMALL: c = 8'h31;
      EXP_LARGE: c = 8'h32;
      EXP_OTHER: c = 8'h58;
      default:   c = 8'h2D;
    endcase
    return c;
  endfunction

  function automatic logic [VibW-1:0] vib_sat(logic [VibW-1:0] ms);
    return (ms > VibLimit) ? VibLimit : ms;
  endfunction

endpackage

// ===== design/bccc_ram.sv =====
`timescale 1ns / 1ps
// Braille cell command controller: generic single-port-write RAM.
// One write and one registered read per cycle; no dependencies.
module bccc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 10
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/braille_cell_command_controller_top.sv =====
`timescale 1ns / 1ps
// Braille cell command controller: top level with command sequencer.
// Depends on bccc_pkg and bccc_ram (cell store).
//
//   channel | dir | handshake             | payload
//   s_axis  | in  | tvalid/tready         | tuser: command; tdata: rx_byte, adc_level
//   m_axis  | out | tvalid/tready, tlast  | tuser: kind; tdata: reply..vibrate_ms
//   cfg     | in  | cfg_we_i (no stall)   | cfg_idx_i, cfg_data_i
//
// One request at a time: ready only in idle. A refresh or read-back reads each
// cell from the RAM and then emits it; the test pattern first writes every cell.
// Valid bits make unwritten cells read as zero after reset, so no clearing pass
// is needed. Output register stalls hold the sequencer.
module braille_cell_command_controller_top #(
  parameter int unsigned NUM_CELLS = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [23:0]             s_axis_tdata,   // rx_byte[7:0], adc_level[17:8]
  input  logic                    s_axis_tuser,   // command
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [31:0]             m_axis_tdata,   // reply_byte[7:0], cell_index[11:8],
                                                  // cell_pattern[17:12], all_high[18],
                                                  // vibrate_ms[31:19]
  output logic [1:0]              m_axis_tuser,   // kind
  output logic                    m_axis_tlast,
  input  logic                    cfg_we_i,
  input  logic [bccc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bccc_pkg::PeriodW-1:0] cfg_data_i
);
  import bccc_pkg::*;

  localparam int unsigned IW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int unsigned LW = $clog2(NUM_CELLS + 1);
  localparam logic [IW-1:0] LastCell = IW'(NUM_CELLS - 1);

  // configuration
  logic [PeriodW-1:0] period_q;
  logic [LevelW-1:0]  none_above_q, small_below_q, large_above_q, large_below_q;
  logic [VibW-1:0]    ack_vib_q, long_vib_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q      <= BlinkPeriodRst;
      none_above_q  <= NoneAboveRst;
      small_below_q <= SmallBelowRst;
      large_above_q <= LargeAboveRst;
      large_below_q <= LargeBelowRst;
      ack_vib_q     <= AckVibRst;
      long_vib_q    <= LongVibRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BLINK_PERIOD: period_q      <= cfg_data_i;
        REG_NONE_ABOVE:   none_above_q  <= cfg_data_i[LevelW-1:0];
        REG_SMALL_BELOW:  small_below_q <= cfg_data_i[LevelW-1:0];
        REG_LARGE_ABOVE:  large_above_q <= cfg_data_i[LevelW-1:0];
        REG_LARGE_BELOW:  large_below_q <= cfg_data_i[LevelW-1:0];
        REG_ACK_VIB:      ack_vib_q     <= cfg_data_i[VibW-1:0];
        REG_LONG_VIB:     long_vib_q    <= cfg_data_i[VibW-1:0];
        default: ;
      endcase
    end
  end

  // control state
  state_e             state_q, state_d;
  logic               in_cmd_q;
  logic [7:0]         in_byte_q;
  logic [LevelW-1:0]  in_lv_q;
  logic [7:0]         saved_q, saved_d;
  logic               blink_en_q, blink_en_d;
  logic               blanked_q, blanked_d;
  logic [IW-1:0]      target_q, target_d;
  logic [PeriodW-1:0] tick_q, tick_d;
  exp_e               exp_q, exp_d;
  logic               load_act_q, load_act_d;
  logic [LW-1:0]      load_idx_q, load_idx_d;
  logic [IW-1:0]      cnt_q, cnt_d;
  logic               ph_rdback_q, ph_rdback_d;
  logic               ph_vib_q, ph_vib_d;
  logic               ph_reply_q, ph_reply_d;
  logic [7:0]         ph_char_q, ph_char_d;
  logic [VibW-1:0]    vib_ms_q, vib_ms_d;
  logic               allh_q, allh_d;
  logic [NUM_CELLS-1:0] valid_q;
  logic               rd_valid_q;

  // output register
  logic               out_valid_q;
  kind_e              out_kind_q, out_kind_d;
  logic [7:0]         out_reply_q, out_reply_d;
  logic [3:0]         out_cell_q, out_cell_d;
  logic [5:0]         out_pat_q, out_pat_d;
  logic               out_allh_q, out_allh_d;
  logic [VibW-1:0]    out_vib_q, out_vib_d;
  logic               out_last_q, out_last_d;
  logic               emit;

  // cell store
  logic               ram_we, ram_re;
  logic [IW-1:0]      ram_waddr, ram_raddr;
  logic [7:0]         ram_wdata, ram_rdata, cell_val;

  bccc_ram #(.Width(8), .Depth(NUM_CELLS)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cell_val = rd_valid_q ? ram_rdata : 8'd0;

  logic               accept;
  logic               slot_free;
  logic [PeriodW-1:0] tick_inc;
  logic [3:0]         blink_k;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !out_valid_q || m_axis_tready;
  assign tick_inc      = tick_q + PeriodW'(1);
  assign blink_k       = in_byte_q[3:0];

  always_comb begin
    state_d     = state_q;
    saved_d     = saved_q;
    blink_en_d  = blink_en_q;
    blanked_d   = blanked_q;
    target_d    = target_q;
    tick_d      = tick_q;
    exp_d       = exp_q;
    load_act_d  = load_act_q;
    load_idx_d  = load_idx_q;
    cnt_d       = cnt_q;
    ph_rdback_d = ph_rdback_q;
    ph_vib_d    = ph_vib_q;
    ph_reply_d  = ph_reply_q;
    ph_char_d   = ph_char_q;
    vib_ms_d    = vib_ms_q;
    allh_d      = allh_q;
    ram_we      = 1'b0;
    ram_waddr   = target_q;
    ram_wdata   = saved_q;
    ram_re      = 1'b0;
    ram_raddr   = cnt_q;
    emit        = 1'b0;
    out_kind_d  = KIND_REPLY;
    out_reply_d = 8'd0;
    out_cell_d  = 4'd0;
    out_pat_d   = 6'd0;
    out_allh_d  = 1'b0;
    out_vib_d   = '0;
    out_last_d  = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d     = S_IDLE;
        cnt_d       = '0;
        ph_rdback_d = 1'b0;
        ph_vib_d    = 1'b0;
        ph_reply_d  = 1'b0;
        ph_char_d   = RPL_OK;
        if (in_cmd_q) begin
          tick_d = tick_inc;
          if (tick_inc == period_q) begin
            tick_d = '0;
            if (blink_en_q) begin
              ram_re    = 1'b1;
              ram_raddr = target_q;
              state_d   = S_BLINK;
            end
          end
        end else if (in_byte_q == CMD_IGNORE) begin
          state_d = S_IDLE;
        end else if (load_act_q) begin
          if (load_idx_q < LW'(NUM_CELLS)) begin
            ram_we     = 1'b1;
            ram_waddr  = load_idx_q[IW-1:0];
            ram_wdata  = in_byte_q;
            load_idx_d = load_idx_q + LW'(1);
          end else begin
            load_act_d = 1'b0;
            load_idx_d = '0;
            if (in_byte_q != CHR_ACK) begin
              ph_char_d = RPL_ERR;
              state_d   = S_REPLY;
            end else begin
              ph_vib_d   = 1'b1;
              ph_reply_d = 1'b1;
              vib_ms_d   = vib_sat(ack_vib_q);
              state_d    = S_RD;
            end
          end
        end else if (in_byte_q[7:4] == CMD_BLINK_HI && blink_k <= BLINK_MAX_K) begin
          if (blink_k >= 4'(NUM_CELLS)) begin
            ph_char_d = RPL_NAK;
            state_d   = S_REPLY;
          end else begin
            target_d   = blink_k[IW-1:0];
            blink_en_d = 1'b1;
          end
        end else begin
          unique case (in_byte_q) inside
            CMD_LOAD: begin
              blink_en_d = 1'b0;
              blanked_d  = 1'b0;
              load_act_d = 1'b1;
              load_idx_d = '0;
            end
            CMD_READ: begin
              ph_rdback_d = 1'b1;
              ph_reply_d  = 1'b1;
              state_d     = S_RD;
            end
            CMD_TEST: begin
              blink_en_d = 1'b0;
              blanked_d  = 1'b0;
              ph_reply_d = 1'b1;
              state_d    = S_FILL;
            end
            CMD_QUERY: begin
              ph_char_d = class_char(exp_q);
              state_d   = S_REPLY;
            end
            CMD_MEASURE: begin
              if (in_lv_q > none_above_q) begin
                exp_d = EXP_NONE;
              end else if (in_lv_q < small_below_q) begin
                exp_d = EXP_SMALL;
              end else if (in_lv_q > large_above_q && in_lv_q < large_below_q) begin
                exp_d = EXP_LARGE;
              end else begin
                exp_d = EXP_OTHER;
              end
              state_d = S_REPLY;
            end
            CMD_HIGH, CMD_LOW: begin
              allh_d  = (in_byte_q == CMD_HIGH);
              state_d = S_ALL;
            end
            CMD_UNBLINK: begin
              blink_en_d = 1'b0;
              blanked_d  = 1'b0;
              ram_we     = 1'b1;
              state_d    = S_RD;
            end
            CMD_LONG_VIB: begin
              vib_ms_d = vib_sat(long_vib_q);
              state_d  = S_VIB;
            end
            default: begin
              ph_char_d = RPL_NAK;
              state_d   = S_REPLY;
            end
          endcase
        end
      end

      S_BLINK: begin
        ram_we = 1'b1;
        if (cell_val != 8'd0) begin
          saved_d = cell_val;
        end
        if (!blanked_q) begin
          ram_wdata = 8'd0;
          blanked_d = 1'b1;
        end else begin
          ram_wdata = (cell_val != 8'd0) ? cell_val : saved_q;
          blanked_d = 1'b0;
        end
        state_d = S_RD;
      end

      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = (cnt_q == '0 || cnt_q == LastCell) ? PAT_EDGE : PAT_INNER;
        if (cnt_q == LastCell) begin
          cnt_d   = '0;
          state_d = S_RD;
        end else begin
          cnt_d = cnt_q + IW'(1);
        end
      end

      S_RD: begin
        ram_re  = 1'b1;
        state_d = S_CELL;
      end

      S_CELL: begin
        if (slot_free) begin
          emit       = 1'b1;
          out_last_d = (cnt_q == LastCell) && !ph_vib_q && !ph_reply_q;
          if (ph_rdback_q) begin
            out_reply_d = cell_val;
          end else begin
            out_kind_d = KIND_CELL;
            out_cell_d = 4'(cnt_q);
            out_pat_d  = cell_val[5:0];
          end
          if (cnt_q == LastCell) begin
            cnt_d = '0;
            if (ph_vib_q) begin
              state_d = S_VIB;
            end else if (ph_reply_q) begin
              state_d = S_REPLY;
            end else begin
              state_d = S_IDLE;
            end
          end else begin
            cnt_d   = cnt_q + IW'(1);
            state_d = S_RD;
          end
        end
      end

      S_VIB: begin
        if (slot_free) begin
          emit       = 1'b1;
          out_kind_d = KIND_VIB;
          out_vib_d  = vib_ms_q;
          out_last_d = !ph_reply_q;
          state_d    = ph_reply_q ? S_REPLY : S_IDLE;
        end
      end

      S_ALL: begin
        if (slot_free) begin
          emit       = 1'b1;
          out_kind_d = KIND_ALL;
          out_allh_d = allh_q;
          out_last_d = 1'b0;
          state_d    = S_REPLY;
        end
      end

      S_REPLY: begin
        if (slot_free) begin
          emit        = 1'b1;
          out_reply_d = ph_char_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      saved_q     <= 8'd0;
      blink_en_q  <= 1'b0;
      blanked_q   <= 1'b0;
      target_q    <= '0;
      tick_q      <= '0;
      exp_q       <= EXP_UNKNOWN;
      load_act_q  <= 1'b0;
      load_idx_q  <= '0;
      cnt_q       <= '0;
      ph_rdback_q <= 1'b0;
      ph_vib_q    <= 1'b0;
      ph_reply_q  <= 1'b0;
      valid_q     <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      saved_q     <= saved_d;
      blink_en_q  <= blink_en_d;
      blanked_q   <= blanked_d;
      target_q    <= target_d;
      tick_q      <= tick_d;
      exp_q       <= exp_d;
      load_act_q  <= load_act_d;
      load_idx_q  <= load_idx_d;
      cnt_q       <= cnt_d;
      ph_rdback_q <= ph_rdback_d;
      ph_vib_q    <= ph_vib_d;
      ph_reply_q  <= ph_reply_d;
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rd_valid_q <= valid_q[ram_raddr];
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_cmd_q  <= s_axis_tuser;
      in_byte_q <= s_axis_tdata[7:0];
      in_lv_q   <= s_axis_tdata[17:8];
    end
    ph_char_q <= ph_char_d;
    vib_ms_q  <= vib_ms_d;
    allh_q    <= allh_d;
    if (emit) begin
      out_kind_q  <= out_kind_d;
      out_reply_q <= out_reply_d;
      out_cell_q  <= out_cell_d;
      out_pat_q   <= out_pat_d;
      out_allh_q  <= out_allh_d;
      out_vib_q   <= out_vib_d;
      out_last_q  <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {out_vib_q, out_allh_q, out_pat_q, out_cell_q, out_reply_q};

  a_load_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_idx_q <= LW'(NUM_CELLS))
    else $error("load index beyond cell count");

  a_target_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(target_q) < NUM_CELLS)
    else $error("blink target beyond cell count");

  a_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("cell store read and write to the same entry");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_EXEC))
    else $error("accepted request not executed");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready && (state_q == S_REPLY || state_q == S_VIB ||
     state_q == S_ALL || state_q == S_CELL)) |=> $stable(state_q))
    else $error("sequencer advanced while output stalled");

endmodule
